// ===== rtl/fit_pkg.sv =====
// ----------------------------------------------------------------------------
// fit_pkg
// Types, codes and field helpers shared by the fault injection trigger unit.
// ----------------------------------------------------------------------------
package fit_pkg;

    // Default number of fault types and the number of types that the
    // configuration registers carry fields for
    localparam int DEF_NUM_TYPES = 4;
    localparam int REG_TYPES     = 4;

    // Width of a type number wide enough to compare against NUM_TYPES (1..16)
    localparam int TYPE_W  = 5;
    // Width of the fault type field on the stream
    localparam int FTYPE_W = 2;

    localparam int TIME_W   = 48;
    localparam int PERIOD_W = 16;
    localparam int INTVL_W  = 16;
    localparam int BURST_W  = 8;
    localparam int MODE_W   = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_MODES     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIODS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVALS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BURSTS    = 3'd3;

    // Action codes carried in tuser
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_CHECK = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF   = 2'd0,
        MODE_FIXED = 2'd1,
        MODE_COUNT = 2'd2,
        MODE_TIME  = 2'd3
    } mode_t;

    // Per-type configuration, sliced out of the registers
    typedef struct packed {
        mode_t                mode;
        logic [PERIOD_W-1:0]  period;
        logic [INTVL_W-1:0]   interval;
        logic [BURST_W-1:0]   burst;
    } type_cfg_t;

    // Per-type state record held in the state memory
    typedef struct packed {
        logic [BURST_W-1:0]   burst_left;
        logic [PERIOD_W-1:0]  phase;
        logic [TIME_W-1:0]    next_trig;
    } rec_t;

    // Slice one type's fields out of the configuration registers;
    // types that have no field in the registers read as all zero
    function automatic type_cfg_t type_cfg(
        input logic [TYPE_W-1:0] t,
        input logic [7:0]        modes,
        input logic [63:0]       periods,
        input logic [63:0]       intervals,
        input logic [31:0]       bursts
    );
        type_cfg_t   c;
        logic [1:0]  i;
        c = '0;
        i = t[1:0];
        if (t < TYPE_W'(REG_TYPES)) begin
            c.mode     = mode_t'(modes[i*MODE_W +: MODE_W]);
            c.period   = periods[i*PERIOD_W +: PERIOD_W];
            c.interval = intervals[i*INTVL_W +: INTVL_W];
            c.burst    = bursts[i*BURST_W +: BURST_W];
        end
        return c;
    endfunction

endpackage

// ===== rtl/fit_state_mem.sv =====
// ----------------------------------------------------------------------------
// fit_state_mem
// Per-type state memory: one write port, one registered read port, and a
// write-back register that forwards the latest write to a read that raced it.
// ----------------------------------------------------------------------------
module fit_state_mem #(
    parameter int NUM_TYPES = fit_pkg::DEF_NUM_TYPES,
    parameter int AW        = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           rd_en,
    input  logic [AW-1:0]  rd_addr,
    output fit_pkg::rec_t  rd_data,
    input  logic           wr_en,
    input  logic [AW-1:0]  wr_addr,
    input  fit_pkg::rec_t  wr_data
);
    import fit_pkg::*;

    rec_t          mem [NUM_TYPES];
    rec_t          rd_q_reg;
    logic [AW-1:0] rd_addr_reg;
    logic          wb_valid_reg;
    logic [AW-1:0] wb_addr_reg;
    rec_t          wb_data_reg;

    // Storage write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, read-old on a same-edge write
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_q_reg    <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // Latest write, kept for forwarding
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wb_valid_reg <= 1'b0;
        end else if (wr_en) begin
            wb_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            wb_addr_reg <= wr_addr;
            wb_data_reg <= wr_data;
        end
    end

    // The write-back register always holds the newest value of its entry
    assign rd_data = (wb_valid_reg && (wb_addr_reg == rd_addr_reg)) ? wb_data_reg : rd_q_reg;

endmodule

// ===== rtl/fit_check.sv =====
// ----------------------------------------------------------------------------
// fit_check
// Decision logic for one check: takes the type's record and configuration,
// returns the inject bit and the updated record.
// ----------------------------------------------------------------------------
module fit_check (
    input  fit_pkg::rec_t                    cur,
    input  fit_pkg::type_cfg_t               tcfg,
    input  logic [fit_pkg::TIME_W-1:0]       time_now,
    output fit_pkg::rec_t                    nxt,
    output logic                             inject
);
    import fit_pkg::*;

    logic [TIME_W-1:0]   rearm_time;
    logic [PERIOD_W:0]   phase_inc;
    logic                fire;

    assign rearm_time = time_now + TIME_W'(tcfg.interval);
    assign phase_inc  = {1'b0, cur.phase} + (PERIOD_W+1)'(1);

    always_comb begin
        nxt    = cur;
        fire   = 1'b0;
        inject = 1'b0;
        if (cur.burst_left != '0) begin
            // pending burst injects whatever the mode
            nxt.burst_left = cur.burst_left - BURST_W'(1);
            inject         = 1'b1;
            if (tcfg.mode == MODE_TIME && cur.burst_left == BURST_W'(1)) begin
                nxt.next_trig = rearm_time;
            end
        end else begin
            unique case (tcfg.mode)
                MODE_FIXED: begin
                    inject = 1'b1;
                end
                MODE_COUNT: begin
                    if (tcfg.period != '0) begin
                        if (phase_inc >= {1'b0, tcfg.period}) begin
                            fire      = 1'b1;
                            nxt.phase = '0;
                        end else begin
                            nxt.phase = phase_inc[PERIOD_W-1:0];
                        end
                    end
                end
                MODE_TIME: begin
                    if (time_now >= cur.next_trig) begin
                        fire = 1'b1;
                        if (tcfg.burst <= BURST_W'(1)) begin
                            nxt.next_trig = rearm_time;
                        end
                    end
                end
                default: begin
                end
            endcase
            // a trigger opens a burst
            if (fire) begin
                inject = 1'b1;
                if (tcfg.burst != '0) begin
                    nxt.burst_left = tcfg.burst - BURST_W'(1);
                end
            end
        end
    end

endmodule

// ===== rtl/fault_injection_trigger_unit.sv =====
// ----------------------------------------------------------------------------
// fault_injection_trigger_unit
// Result path: an accepted check passes the memory read into stage 1, then the
//   decision into the output register that drives m_tvalid.
// Throughput: one transaction per cycle (one read and one write port, write
//   forwarding); a check in stage 1 stalls s_tready while m_tvalid holds a prior result that m_tready has not taken.
// Reset and configuration register writes run a rearm pass over every entry of
//   the state memory, during which s_tready is low.
// ----------------------------------------------------------------------------
module fault_injection_trigger_unit #(
    parameter int NUM_TYPES = fit_pkg::DEF_NUM_TYPES
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [1:0] fault_type
    input  logic [0:0]                         s_tuser,   // [0] action
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // [0] inject
    output logic [1:0]                         m_tuser,   // [1:0] checked_type
    // configuration write port
    input  logic                               cfg_we,
    input  logic [fit_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fit_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import fit_pkg::*;

    localparam int TYPE_AW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;

    // configuration registers
    logic [7:0]   modes_reg;
    logic [63:0]  periods_reg;
    logic [63:0]  intervals_reg;
    logic [31:0]  bursts_reg;
    logic         cfg_hit;

    // rearm pass
    logic               sweep_busy_reg;
    logic [TYPE_AW-1:0] sweep_idx_reg;
    type_cfg_t          sweep_cfg;
    rec_t               sweep_rec;

    // stage 1 (memory data available)
    logic               s1_valid_reg;
    logic               s1_check_reg;
    logic               s1_hit_reg;
    logic [FTYPE_W-1:0] s1_type_reg;
    logic [TYPE_AW-1:0] s1_addr_reg;
    logic               s1_go;
    logic               s1_done;

    logic [TIME_W-1:0]  time_now_reg;

    // output register
    logic               m_valid_reg;
    logic               m_inject_reg;
    logic [FTYPE_W-1:0] m_type_reg;

    // input decode
    logic               accept;
    logic [FTYPE_W-1:0] in_type;
    logic               in_hit;
    logic [TYPE_AW-1:0] in_addr;

    // memory and decision
    rec_t               rd_rec;
    rec_t               chk_rec;
    logic               chk_inject;
    type_cfg_t          s1_cfg;
    logic               mem_we;
    logic [TYPE_AW-1:0] mem_waddr;
    rec_t               mem_wdata;

    // ------------------------------------------------------------------
    // Configuration registers
    assign cfg_hit = cfg_we && (cfg_index <= CFG_BURSTS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modes_reg     <= '0;
            periods_reg   <= '0;
            intervals_reg <= '0;
            bursts_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MODES:     modes_reg     <= cfg_wdata[7:0];
                CFG_PERIODS:   periods_reg   <= cfg_wdata;
                CFG_INTERVALS: intervals_reg <= cfg_wdata;
                CFG_BURSTS:    bursts_reg    <= cfg_wdata[31:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Rearm pass: one entry per cycle after reset and each register write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_busy_reg <= 1'b1;
            sweep_idx_reg  <= '0;
        end else if (cfg_hit) begin
            sweep_busy_reg <= 1'b1;
            sweep_idx_reg  <= '0;
        end else if (sweep_busy_reg) begin
            if (sweep_idx_reg == TYPE_AW'(NUM_TYPES - 1)) begin
                sweep_busy_reg <= 1'b0;
            end else begin
                sweep_idx_reg <= sweep_idx_reg + TYPE_AW'(1);
            end
        end
    end

    assign sweep_cfg = type_cfg(TYPE_W'(sweep_idx_reg), modes_reg, periods_reg,
                                intervals_reg, bursts_reg);

    always_comb begin
        sweep_rec           = '0;
        sweep_rec.next_trig = time_now_reg + TIME_W'(sweep_cfg.interval);
    end

    // ------------------------------------------------------------------
    // Input side
    assign s1_go    = !s1_valid_reg || !s1_check_reg || !m_valid_reg || m_tready;
    assign s1_done  = s1_valid_reg && s1_go;
    assign s_tready = !sweep_busy_reg && s1_go;
    assign accept   = s_tvalid && s_tready;

    assign in_type = s_tdata[FTYPE_W-1:0];
    assign in_hit  = TYPE_W'(in_type) < TYPE_W'(NUM_TYPES);
    assign in_addr = in_hit ? TYPE_AW'(in_type) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_go) begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_check_reg <= (s_tuser[0] == ACT_CHECK);
            s1_hit_reg   <= in_hit;
            s1_type_reg  <= in_type;
            s1_addr_reg  <= in_addr;
        end
    end

    // ------------------------------------------------------------------
    // State memory and decision
    fit_state_mem #(
        .NUM_TYPES (NUM_TYPES),
        .AW        (TYPE_AW)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (in_addr),
        .rd_data (rd_rec),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata)
    );

    assign s1_cfg = type_cfg(TYPE_W'(s1_type_reg), modes_reg, periods_reg,
                             intervals_reg, bursts_reg);

    fit_check u_check (
        .cur      (rd_rec),
        .tcfg     (s1_cfg),
        .time_now (time_now_reg),
        .nxt      (chk_rec),
        .inject   (chk_inject)
    );

    // Write-back: rearm pass has the port to itself
    always_comb begin
        if (sweep_busy_reg) begin
            mem_we    = 1'b1;
            mem_waddr = sweep_idx_reg;
            mem_wdata = sweep_rec;
        end else begin
            mem_we    = s1_done && s1_check_reg && s1_hit_reg;
            mem_waddr = s1_addr_reg;
            mem_wdata = chk_rec;
        end
    end

    // ------------------------------------------------------------------
    // Microsecond clock, advanced in order with the checks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_now_reg <= '0;
        end else if (s1_done && !s1_check_reg) begin
            time_now_reg <= time_now_reg + TIME_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_done && s1_check_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_done && s1_check_reg) begin
            m_inject_reg <= s1_hit_reg && chk_inject;
            m_type_reg   <= s1_type_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_inject_reg};
    assign m_tuser  = m_type_reg;

    // ------------------------------------------------------------------
    // Assertions
    a_no_accept_in_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        sweep_busy_reg |-> !s_tready)
        else $error("input accepted during rearm pass");

    a_accept_fills_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_valid_reg)
        else $error("accepted transaction lost before stage 1");

    a_tick_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_done && !s1_check_reg) |=> (time_now_reg == $past(time_now_reg) + TIME_W'(1)))
        else $error("tick did not advance the clock");

    a_unknown_type_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (TYPE_W'(m_type_reg) >= TYPE_W'(NUM_TYPES))) |-> !m_inject_reg)
        else $error("inject reported for a type beyond NUM_TYPES");

endmodule
